### rtl/core/calu_pkg.sv
// Shared types, widths and constants of the complex ALU with polar output.
`default_nettype none

package calu_pkg;

    localparam int DataW       = 16;
    localparam int FracW       = 8;
    localparam int AngFracW    = 12;
    localparam int AngW        = AngFracW + 3;
    localparam int CordicSteps = 16;
    localparam int CordicGuard = 48 - DataW;
    localparam int SqrtSteps   = DataW;
    localparam int PolarSteps  = (SqrtSteps > CordicSteps) ? SqrtSteps : CordicSteps;

    localparam int QuoW  = DataW + 1;
    localparam int NumW  = 2 * DataW;
    localparam int DenW  = 2 * DataW;
    localparam int RemW  = NumW + FracW;
    localparam int LimW  = DenW + QuoW;
    localparam int SqW   = 2 * DataW;
    localparam int RootW = SqW + 1;
    localparam int CxW   = DataW + 4 + CordicGuard;
    localparam int ZW    = 34;

    localparam int SDataW  = 4 * DataW;
    localparam int OutBits = 3 * DataW + AngW;
    localparam int MDataW  = ((OutBits + 7) / 8) * 8;

    localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;

    // atan(2^-i) in units of 2^-30 radian
    localparam logic [30:0] AtanQ30 [0:31] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
        31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
        31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
        31'd262144,    31'd131072,    31'd65536,     31'd32768,
        31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128,
        31'd64,        31'd32,        31'd16,        31'd8,
        31'd4,         31'd2,         31'd1,         31'd0
    };

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef struct packed {
        op_t                     op;
        logic signed [DataW-1:0] ar;
        logic signed [DataW-1:0] ai;
        logic signed [DataW-1:0] br;
        logic signed [DataW-1:0] bi;
    } operands_t;

    // sign/magnitude numerators plus divisor, ahead of the divider
    typedef struct packed {
        logic            is_div;
        logic            dz;
        logic            re_neg;
        logic [NumW-1:0] re_mag;
        logic            im_neg;
        logic [NumW-1:0] im_mag;
        logic [DenW-1:0] den;
    } front_t;

    // quotient or passed-through magnitude, big flags mark out-of-range values
    typedef struct packed {
        logic            dz;
        logic            re_neg;
        logic            re_big;
        logic [QuoW-1:0] re_q;
        logic            im_neg;
        logic            im_big;
        logic [QuoW-1:0] im_q;
    } quot_t;

    typedef struct packed {
        logic signed [DataW-1:0] result_real;
        logic signed [DataW-1:0] result_imag;
        logic [DataW-1:0]        magnitude;
        logic signed [AngW-1:0]  angle;
        status_t                 status;
    } polar_t;

endpackage

`default_nettype wire

### rtl/core/calu_front.sv
// Operand products and combination into sign/magnitude numerators.
`default_nettype none

module calu_front import calu_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire operands_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output front_t         out_data
);

    localparam int NS = 2;

    typedef struct packed {
        op_t                       op;
        logic signed [DataW:0]     sum_re;
        logic signed [DataW:0]     sum_im;
        logic signed [2*DataW-1:0] p_rr;
        logic signed [2*DataW-1:0] p_ii;
        logic signed [2*DataW-1:0] p_ri;
        logic signed [2*DataW-1:0] p_ir;
        logic signed [2*DataW-1:0] sq_r;
        logic signed [2*DataW-1:0] sq_i;
    } prod_t;

    prod_t  prod_reg, prod_next;
    front_t comb_reg, comb_next;
    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;

    function automatic logic [2*DataW:0] abs33(input logic signed [2*DataW:0] v);
        return v[2*DataW] ? -v : v;
    endfunction

    // Stage 1: all six products, plus sum or difference
    always_comb begin
        logic signed [DataW:0] ar_x, ai_x, br_x, bi_x;
        ar_x = {in_data.ar[DataW-1], in_data.ar};
        ai_x = {in_data.ai[DataW-1], in_data.ai};
        br_x = {in_data.br[DataW-1], in_data.br};
        bi_x = {in_data.bi[DataW-1], in_data.bi};
        prod_next.op = in_data.op;
        if (in_data.op == OP_SUB) begin
            prod_next.sum_re = ar_x - br_x;
            prod_next.sum_im = ai_x - bi_x;
        end else begin
            prod_next.sum_re = ar_x + br_x;
            prod_next.sum_im = ai_x + bi_x;
        end
        prod_next.p_rr = $signed(in_data.ar) * $signed(in_data.br);
        prod_next.p_ii = $signed(in_data.ai) * $signed(in_data.bi);
        prod_next.p_ri = $signed(in_data.ar) * $signed(in_data.bi);
        prod_next.p_ir = $signed(in_data.ai) * $signed(in_data.br);
        prod_next.sq_r = $signed(in_data.br) * $signed(in_data.br);
        prod_next.sq_i = $signed(in_data.bi) * $signed(in_data.bi);
    end

    // Stage 2: combine products per operation
    always_comb begin
        logic signed [2*DataW:0] mre, mim, dre, dim;
        logic [DataW:0]          are, aim;
        logic [2*DataW:0]        amre, amim, adre, adim;
        logic [DenW-1:0]         den;
        mre  = {prod_reg.p_rr[2*DataW-1], prod_reg.p_rr}
             - {prod_reg.p_ii[2*DataW-1], prod_reg.p_ii};
        mim  = {prod_reg.p_ri[2*DataW-1], prod_reg.p_ri}
             + {prod_reg.p_ir[2*DataW-1], prod_reg.p_ir};
        dre  = {prod_reg.p_rr[2*DataW-1], prod_reg.p_rr}
             + {prod_reg.p_ii[2*DataW-1], prod_reg.p_ii};
        dim  = {prod_reg.p_ir[2*DataW-1], prod_reg.p_ir}
             - {prod_reg.p_ri[2*DataW-1], prod_reg.p_ri};
        amre = abs33(mre);
        amim = abs33(mim);
        adre = abs33(dre);
        adim = abs33(dim);
        are  = prod_reg.sum_re[DataW] ? -prod_reg.sum_re : prod_reg.sum_re;
        aim  = prod_reg.sum_im[DataW] ? -prod_reg.sum_im : prod_reg.sum_im;
        den  = unsigned'(prod_reg.sq_r) + unsigned'(prod_reg.sq_i);

        comb_next.is_div = (prod_reg.op == OP_DIV);
        comb_next.dz     = (prod_reg.op == OP_DIV) && (den == '0);
        comb_next.den    = den;
        case (prod_reg.op)
            OP_MUL: begin
                comb_next.re_neg = mre[2*DataW];
                comb_next.re_mag = NumW'(amre >> FracW);
                comb_next.im_neg = mim[2*DataW];
                comb_next.im_mag = NumW'(amim >> FracW);
            end
            OP_DIV: begin
                comb_next.re_neg = dre[2*DataW];
                comb_next.re_mag = adre[NumW-1:0];
                comb_next.im_neg = dim[2*DataW];
                comb_next.im_mag = adim[NumW-1:0];
            end
            default: begin
                comb_next.re_neg = prod_reg.sum_re[DataW];
                comb_next.re_mag = NumW'(are);
                comb_next.im_neg = prod_reg.sum_im[DataW];
                comb_next.im_mag = NumW'(aim);
            end
        endcase
    end

    always_comb begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) prod_reg <= prod_next;
        if (rdy[1]) comb_reg <= comb_next;
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NS-1];
    assign out_data  = comb_reg;

endmodule

`default_nettype wire

### rtl/core/calu_div.sv
// Pipelined restoring divider, one quotient bit per stage, both components at once.
`default_nettype none

module calu_div import calu_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire front_t in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output quot_t       out_data
);

    localparam int NS = QuoW + 1;

    typedef struct packed {
        logic            is_div;
        logic            dz;
        logic            re_neg;
        logic            re_big;
        logic [RemW-1:0] re_rem;
        logic [QuoW-1:0] re_q;
        logic            im_neg;
        logic            im_big;
        logic [RemW-1:0] im_rem;
        logic [QuoW-1:0] im_q;
        logic [DenW-1:0] den;
    } dstage_t;

    dstage_t st_reg  [NS];
    dstage_t st_next [NS];
    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;

    always_comb begin
        logic [RemW-1:0] re_num, im_num;
        logic [LimW-1:0] lim, trial;
        re_num = {in_data.re_mag, {FracW{1'b0}}};
        im_num = {in_data.im_mag, {FracW{1'b0}}};
        lim    = {in_data.den, {QuoW{1'b0}}};

        // Load: a quotient that needs more than QuoW bits only flags saturation
        st_next[0].is_div = in_data.is_div;
        st_next[0].dz     = in_data.dz;
        st_next[0].den    = in_data.den;
        st_next[0].re_neg = in_data.re_neg;
        st_next[0].im_neg = in_data.im_neg;
        st_next[0].re_rem = re_num;
        st_next[0].im_rem = im_num;
        if (in_data.is_div) begin
            st_next[0].re_big = LimW'(re_num) >= lim;
            st_next[0].im_big = LimW'(im_num) >= lim;
            st_next[0].re_q   = '0;
            st_next[0].im_q   = '0;
        end else begin
            st_next[0].re_big = |in_data.re_mag[NumW-1:QuoW];
            st_next[0].im_big = |in_data.im_mag[NumW-1:QuoW];
            st_next[0].re_q   = in_data.re_mag[QuoW-1:0];
            st_next[0].im_q   = in_data.im_mag[QuoW-1:0];
        end

        // One quotient bit per stage, most significant first
        for (int j = 0; j < QuoW; j++) begin
            st_next[j+1] = st_reg[j];
            trial = LimW'(st_reg[j].den) << (QuoW - 1 - j);
            if (st_reg[j].is_div && (LimW'(st_reg[j].re_rem) >= trial)) begin
                st_next[j+1].re_rem          = st_reg[j].re_rem - trial[RemW-1:0];
                st_next[j+1].re_q[QuoW-1-j] = 1'b1;
            end
            if (st_reg[j].is_div && (LimW'(st_reg[j].im_rem) >= trial)) begin
                st_next[j+1].im_rem          = st_reg[j].im_rem - trial[RemW-1:0];
                st_next[j+1].im_q[QuoW-1-j] = 1'b1;
            end
        end
    end

    always_comb begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (rdy[k]) vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (rdy[k]) st_reg[k] <= st_next[k];
        end
    end

    assign in_ready         = rdy[0];
    assign out_valid        = vld_reg[NS-1];
    assign out_data.dz      = st_reg[NS-1].dz;
    assign out_data.re_neg  = st_reg[NS-1].re_neg;
    assign out_data.re_big  = st_reg[NS-1].re_big;
    assign out_data.re_q    = st_reg[NS-1].re_q;
    assign out_data.im_neg  = st_reg[NS-1].im_neg;
    assign out_data.im_big  = st_reg[NS-1].im_big;
    assign out_data.im_q    = st_reg[NS-1].im_q;

endmodule

`default_nettype wire

### rtl/core/calu_polar.sv
// Saturation, then pipelined square root and vectoring CORDIC side by side.
`default_nettype none

module calu_polar import calu_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire quot_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output polar_t     out_data
);

    // saturate, square, sum, steps, round
    localparam int NS = 3 + PolarSteps + 1;

    localparam logic [QuoW-1:0]         SatPos = QuoW'((1 << (DataW - 1)) - 1);
    localparam logic [QuoW-1:0]         SatNeg = QuoW'(1 << (DataW - 1));
    localparam logic signed [DataW-1:0] MaxPos = {1'b0, {(DataW-1){1'b1}}};
    localparam logic signed [DataW-1:0] MinNeg = {1'b1, {(DataW-1){1'b0}}};
    localparam logic signed [ZW-1:0]    RoundZ = ZW'(1 << (29 - AngFracW));
    localparam logic [DataW-1:0]        MagMax = DataW'(46341);
    localparam logic signed [AngW-1:0]  AngMax = AngW'(12868);

    typedef struct packed {
        logic signed [DataW-1:0] rr;
        logic signed [DataW-1:0] ri;
        status_t                 status;
        logic                    zero;
        logic [SqW-1:0]          sq_r;
        logic [SqW-1:0]          sq_i;
        logic [SqW-1:0]          rem;
        logic [RootW-1:0]        root;
        logic signed [CxW-1:0]   x;
        logic signed [CxW-1:0]   y;
        logic signed [ZW-1:0]    z;
        logic [DataW-1:0]        magnitude;
        logic signed [AngW-1:0]  angle;
    } pstage_t;

    pstage_t st_reg  [NS];
    pstage_t st_next [NS];
    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;

    always_comb begin
        logic                      pos_re, neg_re, pos_im, neg_im;
        logic signed [2*DataW-1:0] pr, pi;
        logic signed [CxW-1:0]     x0, y0, dx, dy;
        logic [RootW-1:0]          trial;
        logic signed [ZW-1:0]      zr, at;

        // Stage 0: clamp each component, force zeros on division by zero
        st_next[0] = st_reg[0];
        pos_re = !in_data.re_neg && (in_data.re_big || in_data.re_q > SatPos);
        neg_re =  in_data.re_neg && (in_data.re_big || in_data.re_q > SatNeg);
        pos_im = !in_data.im_neg && (in_data.im_big || in_data.im_q > SatPos);
        neg_im =  in_data.im_neg && (in_data.im_big || in_data.im_q > SatNeg);
        if (in_data.dz) begin
            st_next[0].rr     = '0;
            st_next[0].ri     = '0;
            st_next[0].status = ST_DIVZ;
        end else begin
            st_next[0].rr = pos_re ? MaxPos : neg_re ? MinNeg :
                            in_data.re_neg ? -in_data.re_q[DataW-1:0] : in_data.re_q[DataW-1:0];
            st_next[0].ri = pos_im ? MaxPos : neg_im ? MinNeg :
                            in_data.im_neg ? -in_data.im_q[DataW-1:0] : in_data.im_q[DataW-1:0];
            st_next[0].status = (pos_re || neg_re || pos_im || neg_im) ? ST_SAT : ST_OK;
        end

        // Stage 1: squares and quadrant pre-rotation into the right half plane
        st_next[1] = st_reg[0];
        pr = st_reg[0].rr * st_reg[0].rr;
        pi = st_reg[0].ri * st_reg[0].ri;
        st_next[1].sq_r = unsigned'(pr);
        st_next[1].sq_i = unsigned'(pi);
        st_next[1].zero = (st_reg[0].rr == '0) && (st_reg[0].ri == '0);
        x0 = {{(CxW-DataW-CordicGuard){st_reg[0].rr[DataW-1]}}, st_reg[0].rr,
              {CordicGuard{1'b0}}};
        y0 = {{(CxW-DataW-CordicGuard){st_reg[0].ri[DataW-1]}}, st_reg[0].ri,
              {CordicGuard{1'b0}}};
        if (x0 < 0) begin
            if (y0 >= 0) begin
                st_next[1].x = y0;
                st_next[1].y = -x0;
                st_next[1].z = HalfPiQ30;
            end else begin
                st_next[1].x = -y0;
                st_next[1].y = x0;
                st_next[1].z = -HalfPiQ30;
            end
        end else begin
            st_next[1].x = x0;
            st_next[1].y = y0;
            st_next[1].z = '0;
        end

        // Stage 2: sum of squares seeds the root
        st_next[2]      = st_reg[1];
        st_next[2].rem  = st_reg[1].sq_r + st_reg[1].sq_i;
        st_next[2].root = '0;

        // One root digit and one CORDIC micro-rotation per stage
        for (int j = 0; j < PolarSteps; j++) begin
            st_next[3+j] = st_reg[2+j];
            if (j < SqrtSteps) begin
                trial = st_reg[2+j].root + (RootW'(1) << (2 * (SqrtSteps - 1 - j)));
                if (RootW'(st_reg[2+j].rem) >= trial) begin
                    st_next[3+j].rem  = st_reg[2+j].rem - trial[SqW-1:0];
                    st_next[3+j].root = (st_reg[2+j].root >> 1)
                                      + (RootW'(1) << (2 * (SqrtSteps - 1 - j)));
                end else begin
                    st_next[3+j].root = st_reg[2+j].root >> 1;
                end
            end
            if (j < CordicSteps) begin
                dx = st_reg[2+j].y >>> j;
                dy = st_reg[2+j].x >>> j;
                at = ZW'(AtanQ30[j % 32]);
                if (st_reg[2+j].y >= 0) begin
                    st_next[3+j].x = st_reg[2+j].x + dx;
                    st_next[3+j].y = st_reg[2+j].y - dy;
                    st_next[3+j].z = st_reg[2+j].z + at;
                end else begin
                    st_next[3+j].x = st_reg[2+j].x - dx;
                    st_next[3+j].y = st_reg[2+j].y + dy;
                    st_next[3+j].z = st_reg[2+j].z - at;
                end
            end
        end

        // Last stage: round the root to nearest, round the angle half up
        st_next[NS-1] = st_reg[NS-2];
        st_next[NS-1].magnitude = (RootW'(st_reg[NS-2].rem) > st_reg[NS-2].root) ?
                                  DataW'(st_reg[NS-2].root + RootW'(1)) :
                                  DataW'(st_reg[NS-2].root);
        zr = st_reg[NS-2].z + RoundZ;
        st_next[NS-1].angle = st_reg[NS-2].zero ? '0 : zr[30-AngFracW +: AngW];
    end

    always_comb begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (rdy[k]) vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (rdy[k]) st_reg[k] <= st_next[k];
        end
    end

    assign in_ready             = rdy[0];
    assign out_valid            = vld_reg[NS-1];
    assign out_data.result_real = st_reg[NS-1].rr;
    assign out_data.result_imag = st_reg[NS-1].ri;
    assign out_data.magnitude   = st_reg[NS-1].magnitude;
    assign out_data.angle       = st_reg[NS-1].angle;
    assign out_data.status      = st_reg[NS-1].status;

    a_divz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && (out_data.status == ST_DIVZ) |->
            (out_data.result_real == '0) && (out_data.result_imag == '0) &&
            (out_data.magnitude == '0) && (out_data.angle == '0))
        else $error("division by zero result not cleared");

    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && (out_data.status == ST_SAT) |->
            (out_data.result_real == MaxPos) || (out_data.result_real == MinNeg) ||
            (out_data.result_imag == MaxPos) || (out_data.result_imag == MinNeg))
        else $error("saturation flagged on an unclamped result");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_data.magnitude <= MagMax))
        else $error("magnitude out of range");

    a_ang_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_data.angle <= AngMax) && (out_data.angle >= -AngMax))
        else $error("angle out of range");

endmodule

`default_nettype wire

### rtl/core/complex_alu_with_polar_output.sv
// Top level: complex add/subtract/multiply/divide with rectangular and polar result.
// Path to m_tvalid: front product and combine registers, divider stages, polar stages.
// Throughput: one transfer per cycle unless m_tready stalls; every stage holds one item
// and moves on its own. The depth is set by the divider (one quotient bit per stage)
// and the square root and CORDIC (one step per stage, run side by side).
// Reset (aresetn low at a clock edge) drops every item in flight; no clearing pass.
`default_nettype none

module complex_alu_with_polar_output import calu_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // request channel
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [SDataW-1:0] s_tdata,  // first_real, first_imag, second_real, second_imag
    input  wire logic [1:0]        s_tuser,  // operation
    // result channel
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [MDataW-1:0]      m_tdata,  // result_real, result_imag, magnitude, angle
    output logic [1:0]             m_tuser   // status
);

    operands_t req;
    front_t    front_data;
    quot_t     quot_data;
    polar_t    res;
    logic      front_valid, front_ready;
    logic      quot_valid, quot_ready;

    // Unpack the request; operands sit in tdata from the lowest bits up
    assign req.op = op_t'(s_tuser);
    assign req.ar = s_tdata[0*DataW +: DataW];
    assign req.ai = s_tdata[1*DataW +: DataW];
    assign req.br = s_tdata[2*DataW +: DataW];
    assign req.bi = s_tdata[3*DataW +: DataW];

    // Products and numerators
    calu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (req),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // Quotient bits; other operations pass through with range flags
    calu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (quot_valid),
        .out_ready (quot_ready),
        .out_data  (quot_data)
    );

    // Saturation, modulus and angle; its last stage is the output register
    calu_polar u_polar (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (quot_valid),
        .in_ready  (quot_ready),
        .in_data   (quot_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // Pack the result, zero fill up to whole bytes
    assign m_tdata = MDataW'({res.angle, res.magnitude, res.result_imag, res.result_real});
    assign m_tuser = res.status;

endmodule

`default_nettype wire
